/* rtl/core/scsw_pkg.sv */
// Shared types, constants and the duty pattern table of the square channel.
package scsw_pkg;

  localparam int CYCLE_RATE_DEF  = 4194304;
  localparam int SAMPLE_RATE_DEF = 44100;
  localparam int DUTY_STEPS      = 8;
  localparam int STEP_W          = $clog2(DUTY_STEPS);

  // Phase accumulator: one sample adds 2^ACC_FRAC, value saturates at 2^ACC_W-1.
  localparam int ACC_W    = 28;
  localparam int ACC_FRAC = 20;

  localparam int FREQ_W = 11;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_SAMPLE  = 2'd3
  } mode_e;

  localparam logic [2:0] REG_SWEEP    = 3'd0;
  localparam logic [2:0] REG_DUTY_LEN = 3'd1;
  localparam logic [2:0] REG_ENVELOPE = 3'd2;
  localparam logic [2:0] REG_FREQ_LO  = 3'd3;
  localparam logic [2:0] REG_FREQ_HI  = 3'd4;

  localparam logic CFG_LEFT  = 1'b0;
  localparam logic CFG_RIGHT = 1'b1;

  localparam logic [7:0] RD_MASK_SWEEP    = 8'h80;
  localparam logic [7:0] RD_MASK_DUTY_LEN = 8'h3F;
  localparam logic [7:0] RD_MASK_FREQ_HI  = 8'hBF;
  localparam logic [7:0] RD_UNMAPPED      = 8'hFF;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  reg_offset;
    logic [7:0]  write_data;
    logic [15:0] cycle_count;
  } item_t;

  typedef struct packed {
    logic       channel_on;
    logic [3:0] sample;
    logic [7:0] read_data;
  } result_t;

  // High or low level of the selected 8-step duty pattern.
  function automatic logic duty_high(input logic [1:0] sel, input logic [STEP_W-1:0] step);
    logic [DUTY_STEPS-1:0] pattern;
    unique case (sel)
      2'd0:    pattern = 8'b1000_0000;
      2'd1:    pattern = 8'b1000_0001;
      2'd2:    pattern = 8'b1110_0001;
      default: pattern = 8'b0111_1110;
    endcase
    return pattern[step];
  endfunction

endpackage

/* rtl/core/scsw_in_reg.sv */
// Input register stage that holds one accepted transaction until the core takes it.
module scsw_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  scsw_pkg::item_t      item_i,
  output logic                 valid_o,
  output scsw_pkg::item_t      item_o,
  input  logic                 take_i
);

  logic            vld_q, vld_d;
  scsw_pkg::item_t item_q;

  // Room when empty or when the held item leaves in this cycle.
  assign ready_o = !vld_q || take_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/scsw_out_reg.sv */
// Result register that decouples the core from the downstream handshake.
module scsw_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  scsw_pkg::result_t    result_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output scsw_pkg::result_t    result_o
);

  logic              vld_q, vld_d;
  scsw_pkg::result_t res_q;

  assign ready_o = !vld_q || ready_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

endmodule

/* rtl/core/scsw_core.sv */
// Channel state and its registered update for writes, reads, time advances and samples.
module scsw_core #(
  parameter int CYCLE_RATE  = scsw_pkg::CYCLE_RATE_DEF,
  parameter int SAMPLE_RATE = scsw_pkg::SAMPLE_RATE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic                 cfg_data_i,
  input  logic                 fire_i,
  input  scsw_pkg::item_t      item_i,
  output scsw_pkg::result_t    result_o
);

  localparam int LEN_UNIT = CYCLE_RATE / 256;
  localparam int ENV_UNIT = CYCLE_RATE / 64;
  localparam int SWP_UNIT = CYCLE_RATE / 128;
  localparam int LEN_W    = $clog2(64 * LEN_UNIT + 1);
  localparam int ENV_W    = $clog2(7 * ENV_UNIT + 1);
  localparam int SWP_W    = $clog2(7 * SWP_UNIT + 1);
  localparam int ACC_W    = scsw_pkg::ACC_W;
  localparam int THR_W    = $clog2(SAMPLE_RATE * 2048 + 1);
  localparam int CMP_W    = (THR_W > ACC_W + 1) ? THR_W : ACC_W + 1;
  localparam int FW       = scsw_pkg::FREQ_W;
  localparam int SW       = scsw_pkg::STEP_W;

  localparam logic [FW-1:0] FREQ_MAX = {FW{1'b1}};

  logic             left_q, right_q;
  logic [7:0]       sweep_reg_q, sweep_reg_d;
  logic [7:0]       duty_reg_q, duty_reg_d;
  logic [7:0]       env_reg_q, env_reg_d;
  logic [7:0]       flo_reg_q, flo_reg_d;
  logic [7:0]       fhi_reg_q, fhi_reg_d;
  logic [FW-1:0]    freq_q, freq_d;
  logic [FW-1:0]    shadow_q, shadow_d;
  logic             sounding_q, sounding_d;
  logic             len_unl_q, len_unl_d;
  logic [LEN_W-1:0] len_tmr_q, len_tmr_d;
  logic [ENV_W-1:0] env_tmr_q, env_tmr_d;
  logic [3:0]       volume_q, volume_d;
  logic [SWP_W-1:0] swp_tmr_q, swp_tmr_d;
  logic             swp_act_q, swp_act_d;
  logic [SW-1:0]    step_q, step_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [7:0]       read_data;
  logic [3:0]       sample;

  // Step threshold of the waveform position, and the accumulator after one sample.
  logic [CMP_W-1:0] thr;
  logic [CMP_W-1:0] acc_inc;
  logic [CMP_W-1:0] acc_sub;
  logic             step_adv;

  assign thr      = CMP_W'(SAMPLE_RATE) * CMP_W'(12'd2048 - {1'b0, freq_q});
  assign acc_inc  = CMP_W'(acc_q) + CMP_W'(1 << scsw_pkg::ACC_FRAC);
  assign step_adv = acc_inc > thr;
  assign acc_sub  = step_adv ? acc_inc - thr : acc_inc;

  // One sweep calculation: bit FW of the result flags a sum past the top frequency.
  function automatic logic [FW:0] sweep_step(input logic [FW-1:0] f, input logic [2:0] sh,
                                             input logic up);
    logic [FW-1:0] d;
    d = f >> ({1'b0, sh} + 4'd1);
    if (up) begin
      return {1'b0, f} + {1'b0, d};
    end
    return {1'b0, f - d};
  endfunction

  always_comb begin
    logic [FW-1:0]    f_new;
    logic [FW:0]      calc;
    logic [FW:0]      calc2;
    logic [ENV_W-1:0] env_cnt;
    logic [SWP_W-1:0] swp_cnt;
    logic [LEN_W-1:0] len_cnt;
    logic             up;

    sweep_reg_d = sweep_reg_q;
    duty_reg_d  = duty_reg_q;
    env_reg_d   = env_reg_q;
    flo_reg_d   = flo_reg_q;
    fhi_reg_d   = fhi_reg_q;
    freq_d      = freq_q;
    shadow_d    = shadow_q;
    sounding_d  = sounding_q;
    len_unl_d   = len_unl_q;
    len_tmr_d   = len_tmr_q;
    env_tmr_d   = env_tmr_q;
    volume_d    = volume_q;
    swp_tmr_d   = swp_tmr_q;
    swp_act_d   = swp_act_q;
    step_d      = step_q;
    acc_d       = acc_q;
    read_data   = 8'd0;
    sample      = 4'd0;
    up          = !sweep_reg_q[3];
    f_new       = {item_i.write_data[2:0], freq_q[7:0]};
    calc        = '0;
    calc2       = '0;
    env_cnt     = '0;
    swp_cnt     = '0;
    len_cnt     = '0;

    unique case (item_i.mode)
      scsw_pkg::MODE_WRITE: begin
        unique case (item_i.reg_offset)
          scsw_pkg::REG_SWEEP: begin
            swp_tmr_d   = SWP_W'(item_i.write_data[6:4]) * SWP_W'(SWP_UNIT);
            swp_act_d   = 1'b0;
            sweep_reg_d = item_i.write_data;
          end
          scsw_pkg::REG_DUTY_LEN: begin
            len_tmr_d  = LEN_W'(7'd64 - {1'b0, item_i.write_data[5:0]}) * LEN_W'(LEN_UNIT);
            duty_reg_d = item_i.write_data;
          end
          scsw_pkg::REG_ENVELOPE: begin
            volume_d  = item_i.write_data[7:4];
            env_reg_d = item_i.write_data;
            env_tmr_d = ENV_W'(item_i.write_data[2:0]) * ENV_W'(ENV_UNIT);
          end
          scsw_pkg::REG_FREQ_LO: begin
            freq_d    = {freq_q[10:8], item_i.write_data};
            flo_reg_d = item_i.write_data;
          end
          scsw_pkg::REG_FREQ_HI: begin
            freq_d    = f_new;
            len_unl_d = !item_i.write_data[6];
            fhi_reg_d = item_i.write_data;
            if (item_i.write_data[7]) begin
              // Trigger: restart all units; length reloads only if at zero.
              sounding_d = (env_reg_q[7:3] != 5'd0);
              if (len_tmr_q == '0) begin
                len_tmr_d = LEN_W'(64) * LEN_W'(LEN_UNIT);
              end
              acc_d     = '0;
              step_d    = '0;
              env_tmr_d = ENV_W'(env_reg_q[2:0]) * ENV_W'(ENV_UNIT);
              volume_d  = env_reg_q[7:4];
              shadow_d  = f_new;
              swp_tmr_d = SWP_W'(sweep_reg_q[6:4]) * SWP_W'(SWP_UNIT);
              swp_act_d = (sweep_reg_q[6:4] != 3'd0) || (sweep_reg_q[2:0] != 3'd0);
              if (sweep_reg_q[2:0] != 3'd0) begin
                calc = sweep_step(f_new, sweep_reg_q[2:0], up);
                if (calc[FW]) begin
                  shadow_d   = FREQ_MAX;
                  sounding_d = 1'b0;
                end else begin
                  shadow_d = calc[FW-1:0];
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      scsw_pkg::MODE_READ: begin
        unique case (item_i.reg_offset)
          scsw_pkg::REG_SWEEP:    read_data = sweep_reg_q | scsw_pkg::RD_MASK_SWEEP;
          scsw_pkg::REG_DUTY_LEN: read_data = duty_reg_q | scsw_pkg::RD_MASK_DUTY_LEN;
          scsw_pkg::REG_ENVELOPE: read_data = env_reg_q;
          scsw_pkg::REG_FREQ_HI:  read_data = fhi_reg_q | scsw_pkg::RD_MASK_FREQ_HI;
          default:                read_data = scsw_pkg::RD_UNMAPPED;
        endcase
      end

      scsw_pkg::MODE_ADVANCE: begin
        // Each unit sees the sounding flag as left by the unit before it.
        if (sounding_q && !len_unl_q) begin
          len_cnt   = LEN_W'(item_i.cycle_count);
          len_tmr_d = (len_tmr_q > len_cnt) ? len_tmr_q - len_cnt : '0;
          if (len_tmr_d == '0) begin
            sounding_d = 1'b0;
          end
        end
        if (sounding_d && env_tmr_q != '0) begin
          env_cnt   = ENV_W'(item_i.cycle_count);
          env_tmr_d = (env_tmr_q > env_cnt) ? env_tmr_q - env_cnt : '0;
          if (env_tmr_d == '0) begin
            if (env_reg_q[3]) begin
              if (volume_q != 4'd15) volume_d = volume_q + 4'd1;
            end else begin
              if (volume_q != 4'd0) volume_d = volume_q - 4'd1;
            end
            env_tmr_d = ENV_W'(env_reg_q[2:0]) * ENV_W'(ENV_UNIT);
          end
        end
        if (sounding_d && swp_act_q) begin
          swp_cnt   = SWP_W'(item_i.cycle_count);
          swp_tmr_d = (swp_tmr_q > swp_cnt) ? swp_tmr_q - swp_cnt : '0;
          if (swp_tmr_d == '0) begin
            calc = sweep_step(shadow_q, sweep_reg_q[2:0], up);
            if (calc[FW]) begin
              shadow_d   = FREQ_MAX;
              sounding_d = 1'b0;
              swp_act_d  = 1'b0;
            end else begin
              shadow_d = calc[FW-1:0];
              if (sweep_reg_q[2:0] != 3'd0) begin
                flo_reg_d = calc[7:0];
                fhi_reg_d = {fhi_reg_q[7:3], calc[10:8]};
                freq_d    = calc[FW-1:0];
                // A second calculation only checks for overflow and updates the shadow.
                calc2 = sweep_step(calc[FW-1:0], sweep_reg_q[2:0], up);
                if (calc2[FW]) begin
                  shadow_d   = FREQ_MAX;
                  sounding_d = 1'b0;
                end else begin
                  shadow_d = calc2[FW-1:0];
                end
              end
              swp_tmr_d = SWP_W'(sweep_reg_q[6:4]) * SWP_W'(SWP_UNIT);
            end
          end
        end
      end

      scsw_pkg::MODE_SAMPLE: begin
        if (step_adv) begin
          step_d = (step_q == SW'(scsw_pkg::DUTY_STEPS - 1)) ? '0 : step_q + 1'b1;
        end
        acc_d = (acc_sub[CMP_W-1:ACC_W] != '0) ? {ACC_W{1'b1}} : acc_sub[ACC_W-1:0];
        if ((left_q || right_q) && scsw_pkg::duty_high(duty_reg_q[7:6], step_d)) begin
          sample = volume_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 1'b1;
      right_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scsw_pkg::CFG_LEFT:  left_q  <= cfg_data_i;
        scsw_pkg::CFG_RIGHT: right_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_reg_q <= '0;
      duty_reg_q  <= '0;
      env_reg_q   <= '0;
      flo_reg_q   <= '0;
      fhi_reg_q   <= '0;
      freq_q      <= '0;
      shadow_q    <= '0;
      sounding_q  <= 1'b0;
      len_unl_q   <= 1'b0;
      len_tmr_q   <= '0;
      env_tmr_q   <= '0;
      volume_q    <= '0;
      swp_tmr_q   <= '0;
      swp_act_q   <= 1'b0;
      step_q      <= '0;
      acc_q       <= '0;
    end else if (fire_i) begin
      sweep_reg_q <= sweep_reg_d;
      duty_reg_q  <= duty_reg_d;
      env_reg_q   <= env_reg_d;
      flo_reg_q   <= flo_reg_d;
      fhi_reg_q   <= fhi_reg_d;
      freq_q      <= freq_d;
      shadow_q    <= shadow_d;
      sounding_q  <= sounding_d;
      len_unl_q   <= len_unl_d;
      len_tmr_q   <= len_tmr_d;
      env_tmr_q   <= env_tmr_d;
      volume_q    <= volume_d;
      swp_tmr_q   <= swp_tmr_d;
      swp_act_q   <= swp_act_d;
      step_q      <= step_d;
      acc_q       <= acc_d;
    end
  end

  assign result_o.read_data  = read_data;
  assign result_o.sample     = sample;
  assign result_o.channel_on = sounding_d;

`ifndef NO_ASSERTIONS
  a_on_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> (sounding_q == $past(result_o.channel_on)))
    else $error("channel_on in the result differs from the stored sounding flag");

  a_read_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.mode != scsw_pkg::MODE_READ) |-> (result_o.read_data == 8'd0))
    else $error("read data is nonzero on a transaction that is not a read");

  a_muted_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !left_q && !right_q) |-> (result_o.sample == 4'd0))
    else $error("sample is nonzero with both outputs disabled");

  a_sweep_write_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.mode == scsw_pkg::MODE_WRITE &&
     item_i.reg_offset == scsw_pkg::REG_SWEEP) |=> !swp_act_q)
    else $error("sweep still active after a write to the sweep register");
`endif

endmodule

/* rtl/core/square_channel_with_sweep.sv */
// A transaction is held in the input register, and its result is registered in the result register.
// Throughput: one transaction per cycle while the result register has room; downstream back-pressure bounds it.
// While a finished result waits downstream, the input register can still take one new transaction.
// Reset (rst_ni low, asynchronous): all channel state clears to zero, both output enables to 1.
// Top level of the square channel with sweep, envelope and length counter.
module square_channel_with_sweep #(
  parameter int CYCLE_RATE  = scsw_pkg::CYCLE_RATE_DEF,
  parameter int SAMPLE_RATE = scsw_pkg::SAMPLE_RATE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // reg_offset[2:0], write_data[10:3], cycle_count[26:11]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // read_data[7:0], sample[11:8], channel_on[12]
);

  scsw_pkg::item_t   item_in;
  scsw_pkg::item_t   item_q;
  scsw_pkg::result_t result;
  scsw_pkg::result_t result_q;
  logic              in_vld;
  logic              out_rdy;
  logic              fire;

  assign item_in.mode        = scsw_pkg::mode_e'(s_axis_tuser_i);
  assign item_in.reg_offset  = s_axis_tdata_i[2:0];
  assign item_in.write_data  = s_axis_tdata_i[10:3];
  assign item_in.cycle_count = s_axis_tdata_i[26:11];

  assign fire = in_vld && out_rdy;

  scsw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (item_in),
    .valid_o (in_vld),
    .item_o  (item_q),
    .take_i  (fire)
  );

  scsw_core #(
    .CYCLE_RATE  (CYCLE_RATE),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item_q),
    .result_o   (result)
  );

  scsw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_vld),
    .ready_o  (out_rdy),
    .result_i (result),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (result_q)
  );

  assign m_axis_tdata_o = {3'b000, result_q.channel_on, result_q.sample, result_q.read_data};

endmodule

/* test/tb_square_channel_with_sweep.sv */
// Self-checking testbench for square_channel_with_sweep: directed and random stream traffic.
module tb_square_channel_with_sweep;
  import scsw_pkg::*;

  localparam int IDLE_PCT         = 8;
  localparam int RANDOM_PER_PHASE = 310;
  localparam int MAX_REPORTS      = 100;
  localparam int SWEEP_TICK       = CYCLE_RATE_DEF / 128;
  localparam int ENV_TICK         = CYCLE_RATE_DEF / 64;
  localparam int LEN_TICK         = CYCLE_RATE_DEF / 256;
  localparam int FREQ_MAX         = 2047;
  localparam longint unsigned ACC_ONE   = 64'd1 << ACC_FRAC;
  localparam longint unsigned ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;
  // Bit {pattern, step} is high where the duty waveform is at full level.
  localparam logic [31:0] DUTY_BITS = {8'h7E, 8'hE1, 8'h81, 8'h80};

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = 1'b0;
  logic        cfg_data  = 1'b0;
  logic        in_valid  = 1'b0;
  logic [31:0] in_data   = '0;
  logic [1:0]  in_user   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] out_data;

  square_channel_with_sweep dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  item_t   bus_items[$];
  result_t outputs_due[$];
  int      n_taken = 0;
  int      n_taken_seen = 0;
  int      idle_pct = IDLE_PCT;
  int      phase_count;
  int      mismatches;
  int      n_checked;
  int      n_loud;
  int      n_triggers;
  int      n_saturated;

  // Channel state as the predictor tracks it.
  logic        en_left, en_right;
  logic [7:0]  ch_sweep_r = '0, ch_duty_r = '0, ch_env_r = '0, ch_flo_r = '0, ch_fhi_r = '0;
  logic [10:0] ch_freq = '0, ch_shadow = '0;
  logic        ch_on = 1'b0, ch_len_free = 1'b0, ch_sweep_en = 1'b0;
  logic [20:0] ch_len_tmr = '0;
  logic [18:0] ch_env_tmr = '0;
  logic [17:0] ch_sweep_tmr = '0;
  logic [3:0]  ch_vol = '0;
  logic [2:0]  ch_step = '0;
  logic [27:0] ch_phase = '0;

  function automatic int unsigned tick_down(int unsigned t, int unsigned c);
    return (t > c) ? t - c : 0;
  endfunction

  function automatic int sweep_shift();
    return int'(ch_sweep_r[2:0]) + 1;
  endfunction

  function automatic logic [17:0] sweep_reload();
    return 18'(int'(ch_sweep_r[6:4]) * SWEEP_TICK);
  endfunction

  function automatic logic [18:0] env_reload();
    return 19'(int'(ch_env_r[2:0]) * ENV_TICK);
  endfunction

  // One further sweep calculation on the shadow frequency.
  function automatic void sweep_calc();
    logic [10:0] delta;
    logic [11:0] sum;
    delta = ch_shadow >> sweep_shift();
    sum = {1'b0, ch_shadow} + delta;
    if (ch_sweep_r[3]) begin
      ch_shadow = ch_shadow - delta;
    end else if (sum > FREQ_MAX) begin
      ch_shadow = 11'(FREQ_MAX);
      ch_on = 1'b0;
    end else begin
      ch_shadow = sum[10:0];
    end
  endfunction

  function automatic void store_register(logic [2:0] off, logic [7:0] d);
    case (off)
      REG_SWEEP: begin
        ch_sweep_r = d;
        ch_sweep_tmr = sweep_reload();
        ch_sweep_en = 1'b0;
      end
      REG_DUTY_LEN: begin
        ch_len_tmr = 21'((64 - int'(d[5:0])) * LEN_TICK);
        ch_duty_r = d;
      end
      REG_ENVELOPE: begin
        ch_vol = d[7:4];
        ch_env_r = d;
        ch_env_tmr = env_reload();
      end
      REG_FREQ_LO: begin
        ch_freq[7:0] = d;
        ch_flo_r = d;
      end
      REG_FREQ_HI: begin
        ch_freq[10:8] = d[2:0];
        ch_len_free = !d[6];
        if (d[7]) begin
          n_triggers++;
          ch_on = 1'b1;
          if (ch_len_tmr == 0) ch_len_tmr = 21'(64 * LEN_TICK);
          ch_phase = '0;
          ch_step = '0;
          ch_env_tmr = env_reload();
          ch_vol = ch_env_r[7:4];
          // With volume and direction all zero the output stage is off.
          if (ch_env_r[7:3] == 5'd0) ch_on = 1'b0;
          ch_shadow = ch_freq;
          ch_sweep_tmr = sweep_reload();
          ch_sweep_en = !(ch_sweep_tmr == 0 && ch_sweep_r[2:0] == 3'd0);
          if (ch_sweep_r[2:0] != 3'd0) sweep_calc();
        end
        ch_fhi_r = d;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] register_view(logic [2:0] off);
    case (off)
      REG_SWEEP:    return ch_sweep_r | RD_MASK_SWEEP;
      REG_DUTY_LEN: return ch_duty_r | RD_MASK_DUTY_LEN;
      REG_ENVELOPE: return ch_env_r;
      REG_FREQ_HI:  return ch_fhi_r | RD_MASK_FREQ_HI;
      default:      return RD_UNMAPPED;
    endcase
  endfunction

  function automatic void elapse(logic [15:0] c);
    logic [10:0] delta;
    logic [11:0] sum;
    if (ch_on && !ch_len_free) begin
      ch_len_tmr = 21'(tick_down(ch_len_tmr, c));
      if (ch_len_tmr == 0) ch_on = 1'b0;
    end
    if (ch_on && ch_env_tmr != 0) begin
      ch_env_tmr = 19'(tick_down(ch_env_tmr, c));
      if (ch_env_tmr == 0) begin
        if (ch_env_r[3]) begin
          if (ch_vol != 4'd15) ch_vol = ch_vol + 4'd1;
        end else if (ch_vol != 4'd0) begin
          ch_vol = ch_vol - 4'd1;
        end
        ch_env_tmr = env_reload();
      end
    end
    if (ch_on && ch_sweep_en) begin
      ch_sweep_tmr = 18'(tick_down(ch_sweep_tmr, c));
      if (ch_sweep_tmr == 0) begin
        delta = ch_shadow >> sweep_shift();
        sum = {1'b0, ch_shadow} + delta;
        if (!ch_sweep_r[3] && sum > FREQ_MAX) begin
          ch_shadow = 11'(FREQ_MAX);
          ch_on = 1'b0;
          ch_sweep_en = 1'b0;
        end else begin
          ch_shadow = ch_sweep_r[3] ? ch_shadow - delta : sum[10:0];
          if (ch_sweep_r[2:0] != 3'd0) begin
            ch_flo_r = ch_shadow[7:0];
            ch_fhi_r[2:0] = ch_shadow[10:8];
            ch_freq = ch_shadow;
            sweep_calc();
          end
          ch_sweep_tmr = sweep_reload();
        end
      end
    end
  endfunction

  function automatic logic [3:0] next_sample();
    longint unsigned thr, acc;
    thr = 64'(SAMPLE_RATE_DEF) * (64'd2048 - 64'(ch_freq));
    acc = 64'(ch_phase) + ACC_ONE;
    if (acc > thr) begin
      ch_step = ch_step + 3'd1;
      acc = acc - thr;
    end
    if (acc > ACC_LIMIT) begin
      acc = ACC_LIMIT;
      n_saturated++;
    end
    ch_phase = 28'(acc);
    if (!en_left && !en_right) return 4'd0;
    return DUTY_BITS[{ch_duty_r[7:6], ch_step}] ? ch_vol : 4'd0;
  endfunction

  function automatic result_t channel_next(item_t it);
    result_t r;
    r = '0;
    case (it.mode)
      MODE_WRITE:   store_register(it.reg_offset, it.write_data);
      MODE_READ:    r.read_data = register_view(it.reg_offset);
      MODE_ADVANCE: elapse(it.cycle_count);
      default:      r.sample = next_sample();
    endcase
    r.channel_on = ch_on;
    return r;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(negedge clk_i) begin : drive_inputs
    item_t nxt;
    if (rst_ni) begin
      // A change of the accept count means the held transaction went in at the last edge.
      if (!in_valid || n_taken != n_taken_seen) begin
        if (bus_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = bus_items.pop_front();
          in_valid <= 1'b1;
          in_data <= {5'd0, nxt.cycle_count, nxt.write_data, nxt.reg_offset};
          in_user <= nxt.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
      n_taken_seen = n_taken;
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin : watch_bus
    item_t   seen;
    result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        n_taken++;
        seen.mode = mode_e'(in_user);
        seen.reg_offset = in_data[2:0];
        seen.write_data = in_data[10:3];
        seen.cycle_count = in_data[26:11];
        outputs_due.push_back(channel_next(seen));
      end
      if (out_valid && out_ready) begin
        if (outputs_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, got 0x%04h", $time, out_data);
        end else begin
          want = outputs_due.pop_front();
          n_checked++;
          if (want.sample != 4'd0) n_loud++;
          check_field("read_data", want.read_data, out_data[7:0]);
          check_field("sample", want.sample, out_data[11:8]);
          check_field("channel_on", want.channel_on, out_data[12]);
        end
      end
    end
  end

  task automatic queue_op(mode_e m, logic [2:0] off, logic [7:0] d, logic [15:0] c);
    item_t it;
    it.mode = m;
    it.reg_offset = off;
    it.write_data = d;
    it.cycle_count = c;
    bus_items.push_back(it);
    phase_count++;
  endtask

  // Program the channel, trigger it in most runs, then let it run with a mix of operations or with samples only.
  task automatic queue_tone_run();
    logic       long_run;
    logic [2:0] hi_bits;
    int         ops, sel;
    logic [15:0] cyc;
    long_run = ($urandom_range(0, 39) == 0);
    if ($urandom_range(0, 1)) queue_op(MODE_WRITE, REG_SWEEP, 8'($urandom), '0);
    if ($urandom_range(0, 3) != 0) queue_op(MODE_WRITE, REG_DUTY_LEN, 8'($urandom), '0);
    queue_op(MODE_WRITE, REG_ENVELOPE, ($urandom_range(0, 7) == 0) ?
             8'($urandom_range(0, 7)) : 8'($urandom), '0);
    if (long_run) begin
      // Near the top frequency the accumulator outgrows its step threshold.
      queue_op(MODE_WRITE, REG_FREQ_LO, 8'($urandom_range(248, 255)), '0);
      queue_op(MODE_WRITE, REG_FREQ_HI, {2'b10, 3'($urandom), 3'd7}, '0);
      repeat (300) queue_op(MODE_SAMPLE, '0, '0, '0);
      return;
    end
    queue_op(MODE_WRITE, REG_FREQ_LO, 8'($urandom), '0);
    hi_bits = ($urandom_range(0, 9) < 6) ? 3'd7 : 3'($urandom);
    queue_op(MODE_WRITE, REG_FREQ_HI,
             {($urandom_range(0, 7) != 0), 1'($urandom), 3'($urandom), hi_bits}, '0);
    ops = $urandom_range(4, 30);
    repeat (ops) begin
      sel = $urandom_range(0, 99);
      if (sel < 42) begin
        queue_op(MODE_SAMPLE, 3'($urandom), 8'($urandom), 16'($urandom));
      end else if (sel < 74) begin
        case ($urandom_range(0, 3))
          0:       cyc = 16'($urandom);
          1:       cyc = 16'($urandom_range(16000, 65535));
          2:       cyc = 16'($urandom_range(0, 255));
          default: cyc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        queue_op(MODE_ADVANCE, 3'($urandom), 8'($urandom), cyc);
      end else if (sel < 90) begin
        queue_op(MODE_READ, 3'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        queue_op(MODE_WRITE, 3'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic queue_random_phase();
    phase_count = 0;
    while (phase_count < RANDOM_PER_PHASE) begin
      if ($urandom_range(0, 99) < 15)
        queue_op(mode_e'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 16'($urandom));
      else
        queue_tone_run();
    end
  endtask

  // The sender holds off until every result of the phase has been checked.
  task automatic wait_idle();
    while (bus_items.size() != 0 || in_valid || outputs_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enable(logic idx, logic val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_LEFT) en_left = val;
    else en_right = val;
  endtask

  task automatic set_routing(logic left, logic right);
    write_enable(CFG_LEFT, left);
    write_enable(CFG_RIGHT, right);
  endtask

  initial begin : stimulus
    en_left = 1'b1;
    en_right = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unmapped offsets and the write-only frequency low byte.
    queue_op(MODE_READ, REG_FREQ_LO, 8'h00, 16'h0000);
    queue_op(MODE_READ, 3'd7, 8'h00, 16'h0000);
    queue_op(MODE_WRITE, 3'd5, 8'hFF, 16'hFFFF);
    queue_op(MODE_READ, 3'd5, 8'h00, 16'h0000);
    // Trigger with the output stage off keeps the channel silent.
    queue_op(MODE_WRITE, REG_ENVELOPE, 8'h00, 16'h0000);
    queue_op(MODE_WRITE, REG_FREQ_HI, 8'h80, 16'h0000);
    // Shortest length, loudest volume, envelope period zero, top frequency.
    queue_op(MODE_WRITE, REG_DUTY_LEN, 8'hFF, 16'h0000);
    queue_op(MODE_WRITE, REG_ENVELOPE, 8'hF0, 16'h0000);
    queue_op(MODE_WRITE, REG_FREQ_LO, 8'hFF, 16'h0000);
    queue_op(MODE_WRITE, REG_FREQ_HI, 8'hC7, 16'h0000);
    repeat (3) queue_op(MODE_SAMPLE, 3'd0, 8'h00, 16'h0000);
    // The length runs out, yet samples are still produced.
    queue_op(MODE_ADVANCE, 3'd0, 8'h00, 16'hFFFF);
    queue_op(MODE_SAMPLE, 3'd7, 8'hFF, 16'hFFFF);
    queue_op(MODE_READ, REG_SWEEP, 8'h00, 16'h0000);
    queue_op(MODE_READ, REG_DUTY_LEN, 8'h00, 16'h0000);
    queue_op(MODE_READ, REG_ENVELOPE, 8'h00, 16'h0000);
    queue_op(MODE_READ, REG_FREQ_HI, 8'h00, 16'h0000);
    // Upward sweep from the top frequency clamps and silences at trigger.
    queue_op(MODE_WRITE, REG_SWEEP, 8'h01, 16'h0000);
    queue_op(MODE_WRITE, REG_FREQ_HI, 8'h87, 16'h0000);
    queue_op(MODE_ADVANCE, 3'd0, 8'h00, 16'h0000);
    // Slowest downward sweep with the largest shift, rising envelope from zero.
    queue_op(MODE_WRITE, REG_SWEEP, 8'h7F, 16'h0000);
    queue_op(MODE_WRITE, REG_ENVELOPE, 8'h0F, 16'h0000);
    queue_op(MODE_WRITE, REG_FREQ_HI, 8'h80, 16'h0000);

    queue_random_phase();
    wait_idle();
    set_routing(1'b0, 1'b0);
    queue_random_phase();
    wait_idle();
    set_routing(1'b1, 1'b0);
    queue_random_phase();
    wait_idle();
    set_routing(1'b0, 1'b1);
    idle_pct = 0;
    queue_random_phase();
    wait_idle();
    idle_pct = IDLE_PCT;
    set_routing(1'b1, 1'b1);
    queue_random_phase();
    wait_idle();

    $display("Checked %0d transactions in five phases over four output routings: %0d triggers,",
             n_checked, n_triggers);
    $display("%0d audible samples and %0d saturated accumulator updates.",
             n_loud, n_saturated);
    if (mismatches == 0) begin
      $display("square_channel_with_sweep: match");
    end else begin
      $display("square_channel_with_sweep: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("square_channel_with_sweep: mismatch");
    $finish;
  end

endmodule
